@@ sv/aflcd_pkg.sv @@
// ----------------------------------------------------------------------------
// aflcd_pkg
// Shared types, constants and the control-store program for the frequency
// autorange LCD formatter.
// ----------------------------------------------------------------------------
package aflcd_pkg;

   localparam int FREQ_W      = 32;
   localparam int BCD_DIGITS  = 10;
   localparam int BCD_W       = 4 * BCD_DIGITS;
   localparam int DIGIT_IDX_W = $clog2(BCD_DIGITS);
   localparam int SHIFT_CNT_W = $clog2(FREQ_W + 1);
   localparam int PC_W        = 5;
   localparam int LOOP_CNT_W  = 5;

   localparam logic [FREQ_W-1:0] KHZ_LIMIT = FREQ_W'(1000);
   localparam logic [FREQ_W-1:0] MHZ_LIMIT = FREQ_W'(1000000);

   // Line 2 cursor commands: 0x80 | (0x40 + column)
   localparam logic [7:0] CMD_LINE2  = 8'h80 | 8'h40;
   localparam logic [7:0] CMD_COL0   = CMD_LINE2;
   localparam logic [7:0] CMD_COL6   = CMD_LINE2 + 8'd6;
   localparam logic [7:0] CMD_COL7   = CMD_LINE2 + 8'd7;
   localparam logic [7:0] CMD_COL16  = CMD_LINE2 + 8'd16;
   localparam logic [7:0] CMD_COL17  = CMD_LINE2 + 8'd17;

   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_DOT   = 8'h2E;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_H     = 8'h48;
   localparam logic [7:0] ASCII_M     = 8'h4D;
   localparam logic [7:0] ASCII_K     = 8'h6B;
   localparam logic [7:0] ASCII_Z     = 8'h7A;

   localparam logic [LOOP_CNT_W-1:0] BLANK_REPEAT = LOOP_CNT_W'(19);

   typedef logic [BCD_DIGITS-1:0][3:0] digits_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_WAIT,
      COND_CNT,
      COND_ZERO,
      COND_DIGIT,
      COND_IF_HZ,
      COND_IF_KHZ
   } cond_type;

   typedef enum logic {
      SRC_CONST,
      SRC_DIGIT
   } src_type;

   typedef struct packed {
      logic                   emit;
      src_type                src;
      logic                   is_data;
      logic [7:0]             value;
      logic                   last;
      logic                   ptr_load;
      logic [DIGIT_IDX_W-1:0] ptr_val;
      logic [DIGIT_IDX_W-1:0] low_val;
      logic                   cnt_load;
      cond_type               cond;
      logic [PC_W-1:0]        target;
   } ctrl_word_type;

   typedef struct packed {
      logic done;
      logic hz;
      logic khz;
   } conv_stat_type;

   // program addresses
   localparam logic [PC_W-1:0] PC_BLANK = PC_W'(2);
   localparam logic [PC_W-1:0] PC_MHZ   = PC_W'(5);
   localparam logic [PC_W-1:0] PC_KHZ   = PC_W'(15);
   localparam logic [PC_W-1:0] PC_HZ    = PC_W'(25);

   function automatic ctrl_word_type cw_const(logic is_data, logic [7:0] value, logic last);
      ctrl_word_type w;
      w          = '0;
      w.emit     = 1'b1;
      w.src      = SRC_CONST;
      w.is_data  = is_data;
      w.value    = value;
      w.last     = last;
      w.cond     = COND_NEXT;
      return w;
   endfunction

   function automatic ctrl_word_type cw_ptr(logic is_data, logic [7:0] value,
                                           logic [DIGIT_IDX_W-1:0] hi,
                                           logic [DIGIT_IDX_W-1:0] lo);
      ctrl_word_type w;
      w          = cw_const(is_data, value, 1'b0);
      w.ptr_load = 1'b1;
      w.ptr_val  = hi;
      w.low_val  = lo;
      return w;
   endfunction

   function automatic ctrl_word_type cw_jump(cond_type cond, logic [PC_W-1:0] target);
      ctrl_word_type w;
      w        = '0;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   function automatic ctrl_word_type cw_digit(logic [PC_W-1:0] self);
      ctrl_word_type w;
      w         = '0;
      w.emit    = 1'b1;
      w.src     = SRC_DIGIT;
      w.is_data = 1'b1;
      w.cond    = COND_DIGIT;
      w.target  = self;
      return w;
   endfunction

   function automatic ctrl_word_type ucode_word(logic [PC_W-1:0] pc);
      ctrl_word_type w;
      w = '0;
      unique case (pc)
         5'd0:  w = cw_jump(COND_WAIT, '0);
         5'd1:  begin
            w          = cw_const(1'b0, CMD_COL0, 1'b0);
            w.cnt_load = 1'b1;
         end
         5'd2:  begin
            w        = cw_const(1'b1, ASCII_SPACE, 1'b0);
            w.cond   = COND_CNT;
            w.target = PC_BLANK;
         end
         5'd3:  w = cw_jump(COND_IF_HZ, PC_HZ);
         5'd4:  w = cw_jump(COND_IF_KHZ, PC_KHZ);
         // MHz: integer in digits 9..6, fraction in 5..3
         5'd5:  w = cw_ptr(1'b0, CMD_COL7, DIGIT_IDX_W'(9), DIGIT_IDX_W'(6));
         5'd6:  w = cw_jump(COND_ZERO, 5'd6);
         5'd7:  w = cw_digit(5'd7);
         5'd8:  w = cw_ptr(1'b1, ASCII_DOT, DIGIT_IDX_W'(5), DIGIT_IDX_W'(3));
         5'd9:  w = cw_digit(5'd9);
         5'd10: w = cw_const(1'b0, CMD_COL16, 1'b0);
         5'd11: w = cw_const(1'b1, ASCII_SPACE, 1'b0);
         5'd12: w = cw_const(1'b1, ASCII_M, 1'b0);
         5'd13: w = cw_const(1'b1, ASCII_H, 1'b0);
         5'd14: w = cw_const(1'b1, ASCII_Z, 1'b1);
         // kHz: integer in digits 5..3, fraction in 2..0
         5'd15: w = cw_ptr(1'b0, CMD_COL6, DIGIT_IDX_W'(5), DIGIT_IDX_W'(3));
         5'd16: w = cw_jump(COND_ZERO, 5'd16);
         5'd17: w = cw_digit(5'd17);
         5'd18: w = cw_ptr(1'b1, ASCII_DOT, DIGIT_IDX_W'(2), DIGIT_IDX_W'(0));
         5'd19: w = cw_digit(5'd19);
         5'd20: w = cw_const(1'b0, CMD_COL16, 1'b0);
         5'd21: w = cw_const(1'b1, ASCII_SPACE, 1'b0);
         5'd22: w = cw_const(1'b1, ASCII_K, 1'b0);
         5'd23: w = cw_const(1'b1, ASCII_H, 1'b0);
         5'd24: w = cw_const(1'b1, ASCII_Z, 1'b1);
         // Hz: integer in digits 2..0
         5'd25: w = cw_ptr(1'b0, CMD_COL6, DIGIT_IDX_W'(2), DIGIT_IDX_W'(0));
         5'd26: w = cw_jump(COND_ZERO, 5'd26);
         5'd27: w = cw_digit(5'd27);
         5'd28: w = cw_const(1'b0, CMD_COL17, 1'b0);
         5'd29: w = cw_const(1'b1, ASCII_SPACE, 1'b0);
         5'd30: w = cw_const(1'b1, ASCII_H, 1'b0);
         5'd31: w = cw_const(1'b1, ASCII_Z, 1'b1);
      endcase
      return w;
   endfunction

endpackage

@@ sv/aflcd_req_if.sv @@
// ----------------------------------------------------------------------------
// aflcd_req_if
// Request channel: one frequency item per handshake.
// ----------------------------------------------------------------------------
interface aflcd_req_if;
   logic                           valid;
   logic                           ready;
   logic [aflcd_pkg::FREQ_W-1:0]   frequency;

   modport source (output valid, output frequency, input ready);
   modport sink   (input valid, input frequency, output ready);
endinterface

@@ sv/aflcd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// aflcd_rsp_if
// Response channel: one display byte per handshake.
// ----------------------------------------------------------------------------
interface aflcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_data;
   logic [7:0] value;
   logic       last;

   modport source (output valid, output is_data, output value, output last, input ready);
   modport sink   (input valid, input is_data, input value, input last, output ready);
endinterface

@@ sv/aflcd_bcd_conv.sv @@
// ----------------------------------------------------------------------------
// aflcd_bcd_conv
// Shift-and-add-3 binary to BCD converter, one input bit per cycle, plus
// range flags taken from the binary value at load.
// ----------------------------------------------------------------------------
module aflcd_bcd_conv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [aflcd_pkg::FREQ_W-1:0]  frequency,
   output aflcd_pkg::conv_stat_type      stat,
   output aflcd_pkg::digits_type         digits
);

   logic                                busy_ff, busy_in;
   logic [aflcd_pkg::SHIFT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [aflcd_pkg::FREQ_W-1:0]        bin_ff, bin_in;
   aflcd_pkg::digits_type               bcd_ff, bcd_in;
   logic                                hz_ff, hz_in;
   logic                                khz_ff, khz_in;
   aflcd_pkg::digits_type               adj;
   logic [aflcd_pkg::BCD_W-1:0]         adj_flat;

   always_comb begin
      for (int i = 0; i < aflcd_pkg::BCD_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      adj_flat = adj;
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      hz_in   = hz_ff;
      khz_in  = khz_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = aflcd_pkg::SHIFT_CNT_W'(aflcd_pkg::FREQ_W);
         bin_in  = frequency;
         bcd_in  = '0;
         hz_in   = frequency < aflcd_pkg::KHZ_LIMIT;
         khz_in  = frequency < aflcd_pkg::MHZ_LIMIT;
      end else if (busy_ff) begin
         bcd_in  = aflcd_pkg::digits_type'({adj_flat[aflcd_pkg::BCD_W-2:0],
                                            bin_ff[aflcd_pkg::FREQ_W-1]});
         bin_in  = {bin_ff[aflcd_pkg::FREQ_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != aflcd_pkg::SHIFT_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      hz_ff  <= hz_in;
      khz_ff <= khz_in;
   end

   assign stat.done = !busy_ff;
   assign stat.hz   = hz_ff;
   assign stat.khz  = khz_ff;
   assign digits    = bcd_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("conversion restarted while busy");

   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("converter busy with exhausted bit count");

endmodule

@@ sv/aflcd_seq.sv @@
// ----------------------------------------------------------------------------
// aflcd_seq
// Control-store sequencer: step counter, loop counter, digit pointer and the
// output byte register.
// ----------------------------------------------------------------------------
module aflcd_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  aflcd_pkg::conv_stat_type  conv_stat,
   input  aflcd_pkg::digits_type     digits,
   output logic                      idle,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_is_data,
   output logic [7:0]                rsp_value,
   output logic                      rsp_last
);

   logic                                 busy_ff, busy_in;
   logic [aflcd_pkg::PC_W-1:0]           pc_ff, pc_in;
   logic [aflcd_pkg::LOOP_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [aflcd_pkg::DIGIT_IDX_W-1:0]    ptr_ff, ptr_in;
   logic [aflcd_pkg::DIGIT_IDX_W-1:0]    low_ff, low_in;
   logic                                 valid_ff, valid_in;
   logic                                 is_data_ff, is_data_in;
   logic [7:0]                           value_ff, value_in;
   logic                                 last_ff, last_in;

   aflcd_pkg::ctrl_word_type             cw;
   logic [3:0]                           cur_digit;
   logic                                 can_emit;
   logic                                 hold;
   logic                                 step;
   logic                                 take;
   logic                                 dec_ptr;

   assign cw        = aflcd_pkg::ucode_word(pc_ff);
   assign cur_digit = digits[ptr_ff];
   assign can_emit  = !valid_ff || rsp_ready;
   assign hold      = ((cw.cond == aflcd_pkg::COND_WAIT) && !conv_stat.done) ||
                      (cw.emit && !can_emit);
   assign step      = busy_ff && !hold;

   always_comb begin
      take    = 1'b0;
      dec_ptr = 1'b0;
      unique case (cw.cond)
         aflcd_pkg::COND_NEXT:   take = 1'b0;
         aflcd_pkg::COND_WAIT:   take = 1'b0;
         aflcd_pkg::COND_CNT:    take = (cnt_ff != '0);
         aflcd_pkg::COND_ZERO: begin
            // drop leading zeros but keep the lowest integer digit
            take    = (ptr_ff != low_ff) && (cur_digit == 4'd0);
            dec_ptr = take;
         end
         aflcd_pkg::COND_DIGIT: begin
            take    = (ptr_ff != low_ff);
            dec_ptr = take;
         end
         aflcd_pkg::COND_IF_HZ:  take = conv_stat.hz;
         aflcd_pkg::COND_IF_KHZ: take = conv_stat.khz;
         default:                take = 1'b0;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      cnt_in  = cnt_ff;
      ptr_in  = ptr_ff;
      low_in  = low_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = '0;
      end else if (step) begin
         pc_in = take ? cw.target : pc_ff + 1'b1;
         if (cw.last) begin
            busy_in = 1'b0;
         end
         if (cw.cnt_load) begin
            cnt_in = aflcd_pkg::BLANK_REPEAT;
         end else if ((cw.cond == aflcd_pkg::COND_CNT) && take) begin
            cnt_in = cnt_ff - 1'b1;
         end
         if (cw.ptr_load) begin
            ptr_in = cw.ptr_val;
            low_in = cw.low_val;
         end else if (dec_ptr) begin
            ptr_in = ptr_ff - 1'b1;
         end
      end
   end

   always_comb begin
      valid_in   = valid_ff && !rsp_ready;
      is_data_in = is_data_ff;
      value_in   = value_ff;
      last_in    = last_ff;
      if (step && cw.emit) begin
         valid_in   = 1'b1;
         is_data_in = cw.is_data;
         value_in   = (cw.src == aflcd_pkg::SRC_DIGIT) ?
                      aflcd_pkg::ASCII_ZERO + {4'd0, cur_digit} : cw.value;
         last_in    = cw.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pc_ff    <= '0;
         cnt_ff   <= '0;
         ptr_ff   <= '0;
         low_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         pc_ff    <= pc_in;
         cnt_ff   <= cnt_in;
         ptr_ff   <= ptr_in;
         low_ff   <= low_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_data_ff <= is_data_in;
      value_ff   <= value_in;
      last_ff    <= last_in;
   end

   assign idle        = !busy_ff;
   assign rsp_valid   = valid_ff;
   assign rsp_is_data = is_data_ff;
   assign rsp_value   = value_ff;
   assign rsp_last    = last_ff;

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (step && cw.last) |=> !busy_ff)
      else $error("sequencer still busy after final byte");

   a_ptr_floor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ptr_ff >= low_ff)
      else $error("digit pointer below its lower bound");

   a_dec_digit: assert property (@(posedge clock) disable iff (reset)
      (step && cw.emit && (cw.src == aflcd_pkg::SRC_DIGIT)) |-> cur_digit <= 4'd9)
      else $error("non-decimal digit emitted");

endmodule

@@ sv/frequency_autorange_lcd_formatter.sv @@
// ----------------------------------------------------------------------------
// frequency_autorange_lcd_formatter
// Turns a frequency in hertz into the LCD byte sequence for display line 2,
// auto-ranged to Hz, kHz or MHz.
// ----------------------------------------------------------------------------
// channel | dir | payload                        | per item
// req_ch  | in  | frequency[31:0]                | one frequency
// rsp_ch  | out | is_data, value[7:0], last      | 27 to 35 bytes, last on final
//
// The BCD conversion loads the value and shifts it in bit by bit, then the
// sequencer runs its program: a byte for each emitting step, plus steps for
// the wait exit, range branches and zero skips.
// req_ch.ready is high only while no item is in progress; the final byte may
// still wait in the output register. A stalled rsp_ch holds the current step.
// Synchronous reset clears the sequencer, the converter and the output valid.
// ----------------------------------------------------------------------------
module frequency_autorange_lcd_formatter (
   input  logic        clock,
   input  logic        reset,
   aflcd_req_if.sink   req_ch,
   aflcd_rsp_if.source rsp_ch
);

   logic                       req_accept;
   logic                       seq_idle;
   aflcd_pkg::conv_stat_type   conv_stat;
   aflcd_pkg::digits_type      digits;

   assign req_ch.ready = seq_idle;
   assign req_accept   = req_ch.valid && seq_idle;

   aflcd_bcd_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .frequency (req_ch.frequency),
      .stat      (conv_stat),
      .digits    (digits)
   );

   aflcd_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept),
      .conv_stat   (conv_stat),
      .digits      (digits),
      .idle        (seq_idle),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_is_data (rsp_ch.is_data),
      .rsp_value   (rsp_ch.value),
      .rsp_last    (rsp_ch.last)
   );

endmodule
